@@ rtl/u8250rf_pkg.sv @@
// Shared types and constants for the 8250 UART register file.
package u8250rf_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_RX    = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    PORT_DATA = 3'd0,
    PORT_IER  = 3'd1,
    PORT_IIR  = 3'd2,
    PORT_LCR  = 3'd3,
    PORT_MCR  = 3'd4,
    PORT_LSR  = 3'd5,
    PORT_MSR  = 3'd6,
    PORT_SCR  = 3'd7
  } port_e;

  localparam logic [7:0] LSR_RESET   = 8'h60;
  localparam logic [7:0] LSR_KEEP    = 8'he1;
  localparam logic [7:0] MSR_KEEP    = 8'hf0;
  localparam logic [7:0] IIR_VALUE   = 8'h01;
  localparam logic [7:0] IDLE_DATA   = 8'hff;

  localparam int unsigned LCR_DLAB    = 7;
  localparam int unsigned LSR_DR      = 0;
  localparam int unsigned LSR_OE      = 1;
  localparam int unsigned LSR_THRE    = 5;
  localparam int unsigned LSR_TEMT    = 6;
  localparam int unsigned MCR_LOOP    = 4;

  typedef struct packed {
    cmd_e        cmd;
    logic [2:0]  port;
    logic [7:0]  data;
    logic        tx_acc;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
  } result_t;

endpackage

@@ rtl/uart_8250_register_file_top.sv @@
// Top level of the 8250 UART register file: command port, input register and core.
//
// Each item (bus read, bus write or received byte) is taken when start_i is high
// and busy_o is low; busy_o stays low, so one item can be issued every clock.
// The item is held in the input register, then passes through the register-access
// logic into the result register; the result is on the ports for exactly one cycle
// with valid_o high. Items are answered in order, one result each, and the receiver
// must take results when they come. A read returns the register on read_data_o
// (0xff for writes and received bytes); a data write with the divisor latch bit
// clear shows the byte on tx_byte_o with tx_valid_o high. Status side effects of
// an item are visible to the next item.
module uart_8250_register_file_top import u8250rf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] command_i,
  input  logic [2:0] port_i,
  input  logic [7:0] data_i,
  input  logic       tx_accepted_i,
  output logic       valid_o,
  output logic [7:0] read_data_o,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o
);

  logic    in_valid_q;
  item_t   in_q, in_d;
  logic    res_valid;
  result_t res;
  logic    accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign in_d.cmd    = cmd_e'(command_i);
  assign in_d.port   = port_i;
  assign in_d.data   = data_i;
  assign in_d.tx_acc = tx_accepted_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_d;
    end
  end

  u8250rf_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_q),
    .item_i       (in_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  assign valid_o     = res_valid;
  assign read_data_o = res.read_data;
  assign tx_valid_o  = res.tx_valid;
  assign tx_byte_o   = res.tx_byte;

endmodule

@@ rtl/u8250rf_core.sv @@
// Register state, access side effects and result register of the UART register file.
module u8250rf_core import u8250rf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    res_valid_o,
  output result_t res_o
);

  logic [7:0] rbr_q, rbr_d;
  logic [7:0] dll_q, dll_d;
  logic [7:0] dlm_q, dlm_d;
  logic [7:0] ier_q, ier_d;
  logic [7:0] lcr_q, lcr_d;
  logic [7:0] mcr_q, mcr_d;
  logic [7:0] lsr_q, lsr_d;
  logic [7:0] msr_q, msr_d;
  logic [7:0] scr_q, scr_d;

  logic    res_valid_q;
  result_t res_q, res_d;

  logic       dlab;
  logic [7:0] lsr_rd;
  logic [7:0] msr_rd;
  logic [7:0] mcr_hi;
  logic [7:0] msr_x;

  assign dlab   = lcr_q[LCR_DLAB];
  assign lsr_rd = lsr_q | (8'h01 << LSR_THRE);
  // loopback folds modem control outputs into the status inputs
  assign mcr_hi = {mcr_q[3:0], 4'h0};
  assign msr_x  = msr_q ^ mcr_hi;
  assign msr_rd = mcr_q[MCR_LOOP] ? ({4'h0, msr_x[7:4]} | mcr_hi) : msr_q;

  always_comb begin
    rbr_d = rbr_q;
    dll_d = dll_q;
    dlm_d = dlm_q;
    ier_d = ier_q;
    lcr_d = lcr_q;
    mcr_d = mcr_q;
    lsr_d = lsr_q;
    msr_d = msr_q;
    scr_d = scr_q;
    res_d.read_data = IDLE_DATA;
    res_d.tx_valid  = 1'b0;
    res_d.tx_byte   = 8'h00;
    if (item_valid_i) begin
      unique case (item_i.cmd)
        CMD_READ: begin
          unique case (port_e'(item_i.port))
            PORT_DATA: begin
              if (dlab) begin
                res_d.read_data = dll_q;
              end else begin
                res_d.read_data = rbr_q;
                lsr_d[LSR_DR]   = 1'b0;
              end
            end
            PORT_IER: res_d.read_data = dlab ? dlm_q : ier_q;
            PORT_IIR: res_d.read_data = IIR_VALUE;
            PORT_LCR: res_d.read_data = lcr_q;
            PORT_MCR: res_d.read_data = mcr_q;
            PORT_LSR: begin
              res_d.read_data = lsr_rd;
              lsr_d           = lsr_rd & LSR_KEEP;
            end
            PORT_MSR: begin
              res_d.read_data = msr_rd;
              msr_d           = msr_rd & MSR_KEEP;
            end
            PORT_SCR: res_d.read_data = scr_q;
            default:  res_d.read_data = IDLE_DATA;
          endcase
        end
        CMD_WRITE: begin
          unique case (port_e'(item_i.port))
            PORT_DATA: begin
              if (dlab) begin
                dll_d = item_i.data;
              end else begin
                res_d.tx_valid = 1'b1;
                res_d.tx_byte  = item_i.data;
                if (item_i.tx_acc) lsr_d[LSR_TEMT] = 1'b0;
              end
            end
            PORT_IER: begin
              if (dlab) dlm_d = item_i.data;
              else      ier_d = item_i.data;
            end
            PORT_LCR: lcr_d = item_i.data;
            PORT_MCR: mcr_d = item_i.data;
            PORT_SCR: scr_d = item_i.data;
            default: ;
          endcase
        end
        CMD_RX: begin
          rbr_d         = item_i.data;
          lsr_d[LSR_OE] = lsr_q[LSR_OE] | lsr_q[LSR_DR];
          lsr_d[LSR_DR] = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rbr_q       <= 8'h00;
      dll_q       <= 8'h00;
      dlm_q       <= 8'h00;
      ier_q       <= 8'h00;
      lcr_q       <= 8'h00;
      mcr_q       <= 8'h00;
      lsr_q       <= LSR_RESET;
      msr_q       <= 8'h00;
      scr_q       <= 8'h00;
      res_valid_q <= 1'b0;
    end else begin
      rbr_q       <= rbr_d;
      dll_q       <= dll_d;
      dlm_q       <= dlm_d;
      ier_q       <= ier_d;
      lcr_q       <= lcr_d;
      mcr_q       <= mcr_d;
      lsr_q       <= lsr_d;
      msr_q       <= msr_d;
      scr_q       <= scr_d;
      res_valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef NO_ASSERTIONS
  // transmitter-empty is only restored by reset
  a_temt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !lsr_q[LSR_TEMT] |=> !lsr_q[LSR_TEMT])
    else $error("transmitter-empty set again without reset");

  // holding-empty never clears once set
  a_thre_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lsr_q[LSR_THRE] |=> lsr_q[LSR_THRE])
    else $error("holding-empty cleared");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i |=> res_valid_q)
    else $error("item produced no result");

  a_tx_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.tx_valid) |-> (res_q.read_data == IDLE_DATA))
    else $error("transmit item returned read data");

  // a received byte always leaves data-ready set
  a_rx_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_i && item_i.cmd == CMD_RX) |=> lsr_q[LSR_DR])
    else $error("data-ready not set after receive");
`endif

endmodule
